>>> rtl/u8sd_pkg.sv
// u8sd_pkg: types and constants shared by the utf8 stream decoder modules
// no dependencies; used by u8sd_decode, u8sd_emit and utf8_stream_decoder
`default_nettype none

package u8sd_pkg;

   localparam int CP_W = 21;
   localparam int BYTE_W = 8;
   localparam int CNT_W = 2;
   localparam int REPL_CNT_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
   localparam logic [CP_W-1:0] MIN_3B = 21'h000800;
   localparam logic [CP_W-1:0] MIN_4B = 21'h010000;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_REPL = 1'b0;

   // results caused by one byte: replacements first, then an optional good value
   typedef struct packed {
      logic [REPL_CNT_W-1:0] repl_count;
      logic good;
      logic [CP_W-1:0] value;
   } burst_type;

endpackage

`default_nettype wire

>>> rtl/u8sd_decode.sv
// u8sd_decode: sequence state and per-byte decode into a result burst
// depends on u8sd_pkg
`default_nettype none

module u8sd_decode (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic [u8sd_pkg::BYTE_W-1:0] byte_in,
   input  wire logic end_of_string,
   output u8sd_pkg::burst_type burst
);

   logic [u8sd_pkg::CP_W-1:0] partial_ff, partial_in;
   logic [u8sd_pkg::CNT_W-1:0] expected_ff, expected_in;
   logic [u8sd_pkg::CNT_W-1:0] taken_ff, taken_in;

   logic pending;
   logic cont;
   logic [u8sd_pkg::CNT_W-1:0] taken_inc;
   logic [u8sd_pkg::CP_W-1:0] shifted;
   logic value_ok;
   logic is_ascii, is_lead2, is_lead3, is_lead4;

   assign pending = (expected_ff != '0);
   assign cont = (byte_in[7:6] == 2'b10);
   assign taken_inc = taken_ff + 2'd1;
   assign shifted = {partial_ff[u8sd_pkg::CP_W-7:0], byte_in[5:0]};

   assign is_ascii = ~byte_in[7];
   assign is_lead2 = (byte_in[7:5] == 3'b110) && (byte_in >= 8'hC2);
   assign is_lead3 = (byte_in[7:4] == 4'b1110);
   assign is_lead4 = (byte_in[7:3] == 5'b11110) && (byte_in <= 8'hF4);

   always_comb begin
      value_ok = 1'b1;
      if ((shifted >= u8sd_pkg::SURR_LO) && (shifted <= u8sd_pkg::SURR_HI)) value_ok = 1'b0;
      if (shifted > u8sd_pkg::CP_MAX) value_ok = 1'b0;
      // overlong 3- and 4-byte forms
      if ((expected_ff == 2'd2) && (shifted < u8sd_pkg::MIN_3B)) value_ok = 1'b0;
      if ((expected_ff == 2'd3) && (shifted < u8sd_pkg::MIN_4B)) value_ok = 1'b0;
   end

   always_comb begin
      burst = '0;
      partial_in = partial_ff;
      expected_in = expected_ff;
      taken_in = taken_ff;
      if (pending && cont) begin
         if (taken_inc == expected_ff) begin
            if (value_ok) begin
               burst.good = 1'b1;
               burst.value = shifted;
            end else begin
               burst.repl_count = 3'd1;
            end
            partial_in = '0;
            expected_in = '0;
            taken_in = '0;
         end else if (end_of_string) begin
            burst.repl_count = 3'd1 + {1'b0, taken_inc};
            partial_in = '0;
            expected_in = '0;
            taken_in = '0;
         end else begin
            partial_in = shifted;
            taken_in = taken_inc;
         end
      end else begin
         // interrupted sequence flushes first, then the byte starts afresh
         if (pending) burst.repl_count = 3'd1 + {1'b0, taken_ff};
         partial_in = '0;
         expected_in = '0;
         taken_in = '0;
         priority if (is_ascii) begin
            burst.good = 1'b1;
            burst.value = {13'd0, byte_in};
         end else if (is_lead2) begin
            partial_in = {16'd0, byte_in[4:0]};
            expected_in = 2'd1;
         end else if (is_lead3) begin
            partial_in = {17'd0, byte_in[3:0]};
            expected_in = 2'd2;
         end else if (is_lead4) begin
            partial_in = {18'd0, byte_in[2:0]};
            expected_in = 2'd3;
         end else begin
            burst.repl_count = burst.repl_count + 3'd1;
         end
         if (end_of_string && (expected_in != '0)) begin
            burst.repl_count = burst.repl_count + 3'd1;
            partial_in = '0;
            expected_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         expected_ff <= '0;
         taken_ff <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
         expected_ff <= expected_in;
         taken_ff <= taken_in;
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (expected_ff == '0) |-> (taken_ff == '0) && (partial_ff == '0))
      else $error("idle decoder holds leftover sequence state");

   a_taken_below_expected: assert property (@(posedge clock) disable iff (reset)
      (expected_ff != '0) |-> (taken_ff < expected_ff))
      else $error("continuation count reached sequence length without completing");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      accept |-> ({1'b0, burst.repl_count} + {3'd0, burst.good} <= 4'd4))
      else $error("one byte produced more than four results");

endmodule

`default_nettype wire

>>> rtl/u8sd_emit.sv
// u8sd_emit: result register that plays out one burst, one result per cycle while rsp_ready is high
// depends on u8sd_pkg
`default_nettype none

module u8sd_emit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  wire u8sd_pkg::burst_type burst,
   input  wire logic [u8sd_pkg::CP_W-1:0] replacement,
   output logic free,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [u8sd_pkg::CP_W-1:0] rsp_code_point,
   output logic rsp_malformed,
   output logic rsp_last_of_run
);

   logic [u8sd_pkg::REPL_CNT_W-1:0] repl_left_ff;
   logic good_ff;
   logic [u8sd_pkg::CP_W-1:0] value_ff;
   logic xfer;

   assign rsp_valid = (repl_left_ff != '0) || good_ff;
   assign rsp_malformed = (repl_left_ff != '0);
   assign rsp_code_point = rsp_malformed ? replacement : value_ff;
   assign rsp_last_of_run = rsp_malformed ? ((repl_left_ff == 3'd1) && !good_ff) : 1'b1;
   assign xfer = rsp_valid && rsp_ready;
   // a new burst may load as the last result of the current one leaves
   assign free = !rsp_valid || (rsp_ready && rsp_last_of_run);

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_left_ff <= '0;
         good_ff <= 1'b0;
      end else if (load) begin
         repl_left_ff <= burst.repl_count;
         good_ff <= burst.good;
      end else if (xfer) begin
         if (repl_left_ff != '0) repl_left_ff <= repl_left_ff - 3'd1;
         else good_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) value_ff <= burst.value;
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("burst loaded over results still waiting");

   a_drained_after_last: assert property (@(posedge clock) disable iff (reset)
      (xfer && rsp_last_of_run && !load) |=> !rsp_valid)
      else $error("results remain after last of run was transferred");

   a_good_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_malformed) |-> rsp_last_of_run)
      else $error("decoded value not at end of its run");

endmodule

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: streaming utf-8 decoder with replacement, top level
// depends on u8sd_pkg, u8sd_decode, u8sd_emit
//
// usage:
//   req channel: one byte per transfer with an end_of_string flag.
//   rsp channel: code points, one per transfer; malformed marks a replacement
//   and last_of_run marks the final result caused by one byte. a byte that
//   only opens or extends a sequence gives no result.
//   csr port: apb-style, register 0 at byte address 0 holds the 21-bit
//   replacement code (reset 0xFFFD); write it only while the block is idle.
// timing: the first result of a byte is registered and appears in the cycle after the byte is transferred.
// throughput: one byte per cycle while each byte gives at most one result and
//   rsp_ready stays high; a byte that gives more results holds req_ready low
//   until its last result leaves, set by the single result register that plays out each burst.
// reset: synchronous, clears the open sequence and the result register.
// stall: while rsp_ready is low the pending result holds and req_ready
//   drops once the result register has no room for the next burst.
`default_nettype none

module utf8_stream_decoder (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [u8sd_pkg::BYTE_W-1:0] req_byte_in,
   input  wire logic req_end_of_string,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [u8sd_pkg::CP_W-1:0] rsp_code_point,
   output logic rsp_malformed,
   output logic rsp_last_of_run,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [u8sd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [u8sd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [u8sd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   logic [u8sd_pkg::CP_W-1:0] repl_ff;
   logic accept;
   logic free;
   u8sd_pkg::burst_type burst;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == u8sd_pkg::CSR_IDX_REPL)
                       ? {{(u8sd_pkg::CSR_DATA_W-u8sd_pkg::CP_W){1'b0}}, repl_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= u8sd_pkg::REPL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == u8sd_pkg::CSR_IDX_REPL)) begin
         repl_ff <= csr_pwdata[u8sd_pkg::CP_W-1:0];
      end
   end

   assign req_ready = free;
   assign accept = req_valid && free;

   u8sd_decode u_decode (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .byte_in(req_byte_in),
      .end_of_string(req_end_of_string),
      .burst(burst)
   );

   u8sd_emit u_emit (
      .clock(clock),
      .reset(reset),
      .load(accept),
      .burst(burst),
      .replacement(repl_ff),
      .free(free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_point(rsp_code_point),
      .rsp_malformed(rsp_malformed),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking testbench for utf8_stream_decoder, byte stream in, code points out
// depends on u8sd_pkg and the utf8_stream_decoder rtl; predicts each result
// from its own decoder model and checks every rsp transfer against it
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CP_W = u8sd_pkg::CP_W;
   localparam int BYTE_W = u8sd_pkg::BYTE_W;
   localparam int CSR_ADDR_W = u8sd_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = u8sd_pkg::CSR_DATA_W;
   localparam logic CSR_IDX_REPL = u8sd_pkg::CSR_IDX_REPL;

   localparam int CLK_HALF = 2;
   localparam int DRAIN_LIMIT = 4000;
   localparam int STALL_CYCLES = 80;
   localparam logic [CSR_ADDR_W-1:0] ADDR_REPL = {CSR_IDX_REPL, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = {~CSR_IDX_REPL, 2'b00};
   localparam logic [CP_W-1:0] REPL_DEFAULT = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_TOP = 21'h10FFFF;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic malformed;
      logic last_of_run;
   } cp_result_type;

   typedef enum int {
      SEQ_ASCII, SEQ_TWO, SEQ_THREE, SEQ_FOUR, SEQ_FOUR_RAW, SEQ_CUT, SEQ_NOISE
   } seq_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [BYTE_W-1:0] req_byte_in;
   logic req_end_of_string;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CP_W-1:0] rsp_code_point;
   logic rsp_malformed;
   logic rsp_last_of_run;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // decoder state as the testbench sees it
   logic [CP_W-1:0] repl_cp;
   logic [CP_W-1:0] pend_cp;
   logic [1:0] need_cnt;
   logic [1:0] got_cnt;

   cp_result_type expected_cps[$];
   logic [BYTE_W-1:0] stim_bytes[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_req = 0;
   int hold_left = 0;
   int errors = 0;
   int bytes_sent = 0;
   int strings_sent = 0;
   int cps_checked = 0;
   int repl_checked = 0;

   always #(CLK_HALF) clock = ~clock;

   utf8_stream_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte_in(req_byte_in),
      .req_end_of_string(req_end_of_string),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_code_point(rsp_code_point),
      .rsp_malformed(rsp_malformed),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic bit cp_is_scalar(logic [CP_W-1:0] cp, logic [1:0] need);
      if (cp >= 21'h00D800 && cp <= 21'h00DFFF) return 1'b0;
      if (cp > CP_TOP) return 1'b0;
      // overlong three- and four-byte forms
      if (need == 2'd2 && cp < 21'h000800) return 1'b0;
      if (need == 2'd3 && cp < 21'h010000) return 1'b0;
      return 1'b1;
   endfunction

   task automatic clear_seq();
      pend_cp = '0;
      need_cnt = '0;
      got_cnt = '0;
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      stim_bytes = {stim_bytes, b};
   endtask

   // work out the code points one byte produces: replacements first, then at most one value
   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eos);
      int repl_n;
      bit good;
      bit taken;
      logic [CP_W-1:0] good_cp;
      cp_result_type r;
      repl_n = 0;
      good = 1'b0;
      taken = 1'b0;
      good_cp = '0;
      if (need_cnt != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            taken = 1'b1;
            pend_cp = {pend_cp[CP_W-7:0], b[5:0]};
            got_cnt = got_cnt + 2'd1;
            if (got_cnt == need_cnt) begin
               if (cp_is_scalar(pend_cp, need_cnt)) begin
                  good = 1'b1;
                  good_cp = pend_cp;
               end else begin
                  repl_n = 1;
               end
               clear_seq();
            end else if (eos) begin
               repl_n = 1 + got_cnt;
               clear_seq();
            end
         end else begin
            // interrupted: lead plus every continuation taken so far
            repl_n = 1 + got_cnt;
            clear_seq();
         end
      end
      if (!taken) begin
         if (b < 8'h80) begin
            good = 1'b1;
            good_cp = {13'd0, b};
         end else if (b[7:5] == 3'b110 && b >= 8'hC2) begin
            pend_cp = {16'd0, b[4:0]};
            need_cnt = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            pend_cp = {17'd0, b[3:0]};
            need_cnt = 2'd2;
         end else if (b[7:3] == 5'b11110 && b <= 8'hF4) begin
            pend_cp = {18'd0, b[2:0]};
            need_cnt = 2'd3;
         end else begin
            repl_n = repl_n + 1;
         end
         if (eos && need_cnt != 2'd0) begin
            repl_n = repl_n + 1 + got_cnt;
            clear_seq();
         end
      end
      for (int k = 0; k < repl_n; k++) begin
         r.code_point = repl_cp;
         r.malformed = 1'b1;
         r.last_of_run = !good && (k == repl_n - 1);
         expected_cps = {expected_cps, r};
      end
      if (good) begin
         r.code_point = good_cp;
         r.malformed = 1'b0;
         r.last_of_run = 1'b1;
         expected_cps = {expected_cps, r};
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      req_end_of_string <= eos;
      do @(posedge clock); while (!req_ready);
      decode_byte(b, eos);
      bytes_sent++;
      if (eos) strings_sent++;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_REPL) repl_cp = data[CP_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check_repl();
      logic [CSR_DATA_W-1:0] data;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_REPL;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (data[CP_W-1:0] !== repl_cp) begin
         $error("replacement_code: expected %h, got %h", repl_cp, data[CP_W-1:0]);
         errors++;
      end
      @(posedge clock);
   endtask

   task automatic set_replacement(input logic [CP_W-1:0] cp);
      csr_write(ADDR_REPL, {{(CSR_DATA_W-CP_W){1'b0}}, cp});
      csr_check_repl();
   endtask

   // let every expected result drain, then idle on for a byte still in flight
   task automatic wait_quiet();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (expected_cps.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic add_random_sequence();
      seq_kind_type kind;
      int pick;
      int need;
      int conts;
      logic [CP_W-1:0] cp;
      logic [BYTE_W-1:0] lead;
      pick = $urandom_range(99);
      if (pick < 25) kind = SEQ_ASCII;
      else if (pick < 45) kind = SEQ_TWO;
      else if (pick < 60) kind = SEQ_THREE;
      else if (pick < 75) kind = SEQ_FOUR;
      else if (pick < 82) kind = SEQ_FOUR_RAW;
      else if (pick < 90) kind = SEQ_CUT;
      else kind = SEQ_NOISE;
      case (kind)
         SEQ_ASCII: begin
            queue_byte(8'($urandom_range(8'h7F)));
         end
         SEQ_TWO: begin
            cp = 21'($urandom_range(12'h7FF, 8'h80));
            queue_byte({3'b110, cp[10:6]});
            queue_byte({2'b10, cp[5:0]});
         end
         SEQ_THREE: begin
            // full 16-bit range, so overlong forms and surrogates show up too
            cp = 21'($urandom_range(16'hFFFF));
            queue_byte({4'b1110, cp[15:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
         end
         SEQ_FOUR: begin
            cp = 21'($urandom_range(CP_TOP, 21'h010000));
            queue_byte({5'b11110, cp[20:18]});
            queue_byte({2'b10, cp[17:12]});
            queue_byte({2'b10, cp[11:6]});
            queue_byte({2'b10, cp[5:0]});
         end
         SEQ_FOUR_RAW: begin
            queue_byte(8'($urandom_range(8'hF4, 8'hF0)));
            repeat (3) queue_byte({2'b10, 6'($urandom_range(63))});
         end
         SEQ_CUT: begin
            lead = 8'($urandom_range(8'hF4, 8'hC2));
            need = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
            conts = $urandom_range(need - 1);
            queue_byte(lead);
            repeat (conts) queue_byte({2'b10, 6'($urandom_range(63))});
         end
         default: begin
            queue_byte(8'($urandom_range(8'hFF)));
         end
      endcase
   endtask

   task automatic test_csr_access();
      csr_check_repl();
      // a write past the last register must leave the replacement code alone
      csr_write(ADDR_SPARE, $urandom());
      csr_check_repl();
   endtask

   task automatic test_directed_bytes();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
      // smallest two-byte form
      send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
      // surrogate
      send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
      // overlong three-byte form
      send_byte(8'hE0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'hBF, 1'b0);
      // largest scalar, then one past it
      send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      // bad leads and a stray continuation
      send_byte(8'hC0, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
      // four-byte sequence broken by ascii gives three replacements, then the letter
      send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
      // end of string with a sequence open flushes it
      send_byte(8'hE1, 1'b0); send_byte(8'h80, 1'b1);
      wait_quiet();
   endtask

   task automatic test_random_stream(input int nbytes, input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      stim_bytes.delete();
      while (stim_bytes.size() < nbytes) add_random_sequence();
      foreach (stim_bytes[i]) send_byte(stim_bytes[i], $urandom_range(99) < 8);
      wait_quiet();
   endtask

   // receiver holds off while bursts of replacements keep arriving
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req = STALL_CYCLES;
      repeat (6) begin
         send_byte(8'hF0, 1'b0);
         send_byte({2'b10, 6'($urandom_range(6'h0F, 6'h10))}, 1'b0);
         send_byte({2'b10, 6'($urandom_range(63))}, 1'b0);
         send_byte(8'($urandom_range(8'h7F)), 1'b0);
         send_byte(8'($urandom_range(8'hFF, 8'hF5)), 1'b0);
      end
      wait_quiet();
   endtask

   // result side: check every transfer
   always @(posedge clock) begin
      cp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cps.size() == 0) begin
            $error("unexpected result transfer: code_point %h", rsp_code_point);
            errors++;
         end else begin
            want = expected_cps.pop_front();
            cps_checked++;
            if (want.malformed) repl_checked++;
            if (rsp_code_point !== want.code_point) begin
               $error("code_point: expected %h, got %h", want.code_point, rsp_code_point);
               errors++;
            end
            if (rsp_malformed !== want.malformed) begin
               $error("malformed: expected %b, got %b", want.malformed, rsp_malformed);
               errors++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b", want.last_of_run, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // receiver: random ready, long hold-off on request
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_in = '0;
      req_end_of_string = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repl_cp = REPL_DEFAULT;
      clear_seq();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_csr_access();
      test_directed_bytes();
      set_replacement('0);
      test_random_stream(16, 56, 0);
      set_replacement(CP_TOP);
      test_random_stream(16, 0, 56);
      set_replacement(21'($urandom_range(CP_TOP)));
      test_random_stream(16, 9, 9);
      set_replacement(REPL_DEFAULT);
      test_random_stream(16, 0, 0);
      test_result_backpressure();

      if (expected_cps.size() != 0) begin
         $error("%0d expected code points never came out", expected_cps.size());
         errors++;
      end
      $display("run: %0d bytes in (%0d ends of string), %0d code points checked, %0d replacements",
               bytes_sent, strings_sent, cps_checked, repl_checked);
      $display("run: csr readback, directed edge cases, four idle/stall mixes, long result stall");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
